/* hw/rtl/wsdf_pkg.sv */
package wsdf_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned OpcodeW  = 4;
    localparam int unsigned LenW     = 64;
    localparam int unsigned KeyW     = 32;
    localparam int unsigned FieldCntW = 4;

    localparam logic [6:0] Len7Ext16 = 7'd126;
    localparam logic [6:0] Len7Ext64 = 7'd127;

    localparam logic [FieldCntW-1:0] Ext16Bytes = 4'd2;
    localparam logic [FieldCntW-1:0] Ext64Bytes = 4'd8;
    localparam logic [FieldCntW-1:0] KeyBytes   = 4'd4;

    // One-hot parse phase.
    typedef enum logic [4:0] {
        PH_HEAD0   = 5'b00001,
        PH_HEAD1   = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

endpackage

/* hw/rtl/websocket_frame_deframer.sv */
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------------------
// input    | in        | in_valid/in_ready  | rx_byte
// result   | out       | out_valid/out_ready| payload_byte, final_flag, frame_opcode,
//          |           |                    | empty_frame, last_of_frame
//
// One byte is accepted per cycle; its result, if any, appears in the output
// register on the next cycle. The parse state advances on the accepting edge.
// An input byte is taken whenever the output register is empty or is being
// drained in the same cycle, so a stalled result holds off only new input.
// Reset (rst_n, asynchronous) returns the parser to expect a first header byte.
module websocket_frame_deframer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [wsdf_pkg::ByteW-1:0]   rx_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [wsdf_pkg::ByteW-1:0]   payload_byte,
    output logic                         final_flag,
    output logic [wsdf_pkg::OpcodeW-1:0] frame_opcode,
    output logic                         empty_frame,
    output logic                         last_of_frame
);
    import wsdf_pkg::*;

    phase_t               phase_reg, phase_next;
    logic                 fin_reg, fin_next;
    logic [OpcodeW-1:0]   opcode_reg, opcode_next;
    logic [LenW-1:0]      len_reg, len_next;
    logic [FieldCntW-1:0] left_reg, left_next;
    logic [KeyW-1:0]      key_reg, key_next;
    logic [1:0]           kpos_reg, kpos_next;
    logic [LenW-1:0]      remain_reg, remain_next;

    logic                 out_valid_reg;
    logic [ByteW-1:0]     data_reg;
    logic                 fin_out_reg;
    logic [OpcodeW-1:0]   opcode_out_reg;
    logic                 empty_reg;
    logic                 last_reg;

    logic                 accept;
    logic                 emit;
    logic [ByteW-1:0]     emit_data;
    logic                 emit_empty;
    logic                 emit_last;
    logic [ByteW-1:0]     key_byte;
    logic [FieldCntW-1:0] left_dec;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign left_dec = left_reg - 4'd1;

    always_comb
    begin
        case (kpos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        len_next    = len_reg;
        left_next   = left_reg;
        key_next    = key_reg;
        kpos_next   = kpos_reg;
        remain_next = remain_reg;
        emit        = 1'b0;
        emit_data   = '0;
        emit_empty  = 1'b0;
        emit_last   = 1'b0;

        case (phase_reg)
            PH_HEAD1:
            begin
                if (rx_byte[6:0] == Len7Ext16)
                begin
                    len_next   = '0;
                    left_next  = Ext16Bytes;
                    phase_next = PH_EXTLEN;
                end
                else if (rx_byte[6:0] == Len7Ext64)
                begin
                    len_next   = '0;
                    left_next  = Ext64Bytes;
                    phase_next = PH_EXTLEN;
                end
                else
                begin
                    len_next   = {{(LenW-7){1'b0}}, rx_byte[6:0]};
                    left_next  = KeyBytes;
                    phase_next = PH_KEY;
                end
            end
            PH_EXTLEN:
            begin
                len_next  = {len_reg[LenW-ByteW-1:0], rx_byte};
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    left_next  = KeyBytes;
                    phase_next = PH_KEY;
                end
            end
            PH_KEY:
            begin
                key_next  = {key_reg[KeyW-ByteW-1:0], rx_byte};
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    kpos_next   = 2'd0;
                    remain_next = len_reg;
                    if (len_reg == '0)
                    begin
                        phase_next = PH_HEAD0;
                        emit       = 1'b1;
                        emit_empty = 1'b1;
                        emit_last  = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                kpos_next   = kpos_reg + 2'd1;
                remain_next = remain_reg - 64'd1;
                emit        = 1'b1;
                emit_data   = rx_byte ^ key_byte;
                // The count has not been decremented yet, so one left means last.
                emit_last   = (remain_reg == 64'd1);
                if (emit_last)
                begin
                    phase_next = PH_HEAD0;
                end
            end
            default:
            begin
                // First header byte; an unused phase code is handled the same way.
                fin_next    = rx_byte[7];
                opcode_next = rx_byte[3:0];
                phase_next  = PH_HEAD1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEAD0;
            fin_reg       <= 1'b0;
            opcode_reg    <= '0;
            len_reg       <= '0;
            left_reg      <= '0;
            key_reg       <= '0;
            kpos_reg      <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg  <= phase_next;
                fin_reg    <= fin_next;
                opcode_reg <= opcode_next;
                len_reg    <= len_next;
                left_reg   <= left_next;
                key_reg    <= key_next;
                kpos_reg   <= kpos_next;
                remain_reg <= remain_next;
            end
            if (accept)
            begin
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            data_reg       <= emit_data;
            fin_out_reg    <= fin_reg;
            opcode_out_reg <= opcode_reg;
            empty_reg      <= emit_empty;
            last_reg       <= emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = data_reg;
    assign final_flag    = fin_out_reg;
    assign frame_opcode  = opcode_out_reg;
    assign empty_frame   = empty_reg;
    assign last_of_frame = last_reg;

endmodule

/* tb/sv/wsdf_unmask_checker.sv */
module wsdf_unmask_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [wsdf_pkg::ByteW-1:0]   rx_byte,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [wsdf_pkg::ByteW-1:0]   payload_byte,
    input  logic                         final_flag,
    input  logic [wsdf_pkg::OpcodeW-1:0] frame_opcode,
    input  logic                         empty_frame,
    input  logic                         last_of_frame,
    output int                           failures,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import wsdf_pkg::*;

    typedef struct packed {
        logic [ByteW-1:0]   data;
        logic               fin;
        logic [OpcodeW-1:0] opcode;
        logic               empty;
        logic               last;
    } unmasked_t;

    phase_t               frame_phase = PH_HEAD0;
    logic                 cur_fin = 1'b0;
    logic [OpcodeW-1:0]   cur_opcode = '0;
    logic [LenW-1:0]      len_shift = '0;
    logic [FieldCntW-1:0] field_count = '0;
    logic [KeyW-1:0]      mask_key = '0;
    logic [1:0]           key_idx = '0;
    logic [LenW-1:0]      bytes_to_go = '0;

    unmasked_t unmasked_q[$];
    unmasked_t want;
    int        fail_total = 0;
    int        queued = 0;

    assign failures = fail_total;
    assign pending  = queued;

    // Advances the parser by one byte and queues the result it causes, if any.
    task automatic parse_rx_byte(input logic [ByteW-1:0] b);
        unmasked_t        r;
        logic [ByteW-1:0] k;
        case (frame_phase)
            PH_HEAD1:
            begin
                len_shift = '0;
                if (b[6:0] == Len7Ext16)
                begin
                    field_count = Ext16Bytes;
                    frame_phase = PH_EXTLEN;
                end
                else if (b[6:0] == Len7Ext64)
                begin
                    field_count = Ext64Bytes;
                    frame_phase = PH_EXTLEN;
                end
                else
                begin
                    len_shift   = {57'd0, b[6:0]};
                    field_count = KeyBytes;
                    frame_phase = PH_KEY;
                end
            end
            PH_EXTLEN:
            begin
                len_shift   = {len_shift[LenW-9:0], b};
                field_count = field_count - 1'b1;
                if (field_count == '0)
                begin
                    field_count = KeyBytes;
                    frame_phase = PH_KEY;
                end
            end
            PH_KEY:
            begin
                mask_key    = {mask_key[KeyW-9:0], b};
                field_count = field_count - 1'b1;
                if (field_count == '0)
                begin
                    key_idx     = '0;
                    bytes_to_go = len_shift;
                    if (bytes_to_go == '0)
                    begin
                        frame_phase = PH_HEAD0;
                        r.data      = '0;
                        r.fin       = cur_fin;
                        r.opcode    = cur_opcode;
                        r.empty     = 1'b1;
                        r.last      = 1'b1;
                        unmasked_q.push_back(r);
                    end
                    else
                    begin
                        frame_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                // Key bytes are applied most significant first.
                k           = mask_key[5'(31 - 8*key_idx) -: 8];
                key_idx     = key_idx + 1'b1;
                bytes_to_go = bytes_to_go - 1'b1;
                r.data      = b ^ k;
                r.fin       = cur_fin;
                r.opcode    = cur_opcode;
                r.empty     = 1'b0;
                r.last      = (bytes_to_go == '0);
                if (r.last)
                begin
                    frame_phase = PH_HEAD0;
                end
                unmasked_q.push_back(r);
            end
            default:
            begin
                cur_fin     = b[7];
                cur_opcode  = b[3:0];
                frame_phase = PH_HEAD1;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] expected,
                               input logic [7:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
            fail_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_phase = PH_HEAD0;
            cur_fin     = 1'b0;
            cur_opcode  = '0;
            len_shift   = '0;
            field_count = '0;
            mask_key    = '0;
            key_idx     = '0;
            bytes_to_go = '0;
            unmasked_q.delete();
        end
        else
        begin
            // A result never comes from a byte taken on the same edge, so the
            // comparison goes first.
            if (out_valid && out_ready)
            begin
                if (unmasked_q.size() == 0)
                begin
                    $error("result with no item expected: payload_byte 0x%0h", payload_byte);
                    fail_total++;
                end
                else
                begin
                    want = unmasked_q.pop_front();
                    check_field("payload_byte", want.data, payload_byte);
                    check_field("final_flag", 8'(want.fin), 8'(final_flag));
                    check_field("frame_opcode", 8'(want.opcode), 8'(frame_opcode));
                    check_field("empty_frame", 8'(want.empty), 8'(empty_frame));
                    check_field("last_of_frame", 8'(want.last), 8'(last_of_frame));
                end
            end
            if (in_valid && in_ready)
            begin
                parse_rx_byte(rx_byte);
            end
        end
        queued = unmasked_q.size();
    end

endmodule

/* tb/sv/websocket_frame_deframer_test.sv */
module websocket_frame_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wsdf_pkg::*;

    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned RandomBytes = 500;

    typedef enum int unsigned {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } len_form_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [ByteW-1:0]   rx_byte = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [ByteW-1:0]   payload_byte;
    logic               final_flag;
    logic [OpcodeW-1:0] frame_opcode;
    logic               empty_frame;
    logic               last_of_frame;

    int          failures;
    int          pending;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned burst_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int unsigned stall_step = 0;

    len_form_t   form;
    logic [63:0] frame_len;

    websocket_frame_deframer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_byte  (payload_byte),
        .final_flag    (final_flag),
        .frame_opcode  (frame_opcode),
        .empty_frame   (empty_frame),
        .last_of_frame (last_of_frame)
    );

    wsdf_unmask_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_byte  (payload_byte),
        .final_flag    (final_flag),
        .frame_opcode  (frame_opcode),
        .empty_frame   (empty_frame),
        .last_of_frame (last_of_frame),
        .failures      (failures),
        .pending       (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("websocket_frame_deframer_test NOT OK");
            $finish;
        end
    end

    // The receiver switches its stall pattern among three kinds: always ready,
    // a random pattern, or a mostly ready one.
    always @(negedge clk)
    begin
        if (stall_step % 64 == 0)
        begin
            case ($urandom_range(0, 2))
                0:       stall_pattern = 16'hFFFF;
                1:       stall_pattern = 16'($urandom);
                default: stall_pattern = 16'($urandom) | 16'($urandom);
            endcase
        end
        if (rst_n)
        begin
            out_ready <= stall_pattern[4'(stall_step % 16)];
        end
        stall_step++;
    end

    // Sends one item; bursts of back-to-back items alternate with idle gaps.
    task automatic send_byte(input logic [ByteW-1:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [ByteW-1:0] head, input logic mask,
                              input len_form_t len_form, input logic [63:0] len,
                              input logic [KeyW-1:0] key, input int unsigned body_len);
        int unsigned i;
        send_byte(head);
        case (len_form)
            LEN_EXT16:
            begin
                send_byte({mask, Len7Ext16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            LEN_EXT64:
            begin
                send_byte({mask, Len7Ext64});
                for (i = 0; i < 8; i++)
                    send_byte(len[6'(63 - 8*i) -: 8]);
            end
            default:
            begin
                send_byte({mask, len[6:0]});
            end
        endcase
        for (i = 0; i < 4; i++)
            send_byte(key[5'(31 - 8*i) -: 8]);
        for (i = 0; i < body_len; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty frame with fin, reserved bits and the top opcode, mask bit clear.
        send_frame(8'hFF, 1'b0, LEN_SHORT, 64'd0, 32'h0000_0000, 0);
        // 16-bit length below 126, all-ones key.
        send_frame(8'h70, 1'b1, LEN_EXT16, 64'd3, 32'hFFFF_FFFF, 3);
        // 64-bit length of one byte, mask bit clear but the key still applies.
        send_frame(8'h81, 1'b0, LEN_EXT64, 64'd1, 32'h1234_5678, 1);

        while (bytes_sent < RandomBytes)
        begin
            case ($urandom_range(0, 9))
                6, 7:    form = LEN_EXT16;
                8, 9:    form = LEN_EXT64;
                default: form = LEN_SHORT;
            endcase
            case (form)
                LEN_EXT16: frame_len = ($urandom_range(0, 3) == 0)
                                       ? 64'($urandom_range(126, 300))
                                       : 64'($urandom_range(0, 20));
                LEN_EXT64: frame_len = 64'($urandom_range(0, 20));
                default:   frame_len = ($urandom_range(0, 7) == 0)
                                       ? 64'($urandom_range(0, 125))
                                       : 64'($urandom_range(0, 6));
            endcase
            send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), form,
                       frame_len, $urandom, 32'(frame_len));
        end

        // A 64-bit length with its top bit set is taken whole; only the start
        // of that payload is sent, so the frame never ends.
        send_frame(8'h82, 1'b1, LEN_EXT64, 64'h8000_0000_0000_0005, $urandom, 8);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (failures == 0)
            $display("websocket_frame_deframer_test OK");
        else
            $display("websocket_frame_deframer_test NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/wsdf_pkg.sv
hw/rtl/websocket_frame_deframer.sv
tb/sv/wsdf_unmask_checker.sv
tb/sv/websocket_frame_deframer_test.sv
